[design/aoe_pkg.sv]
// aoe_pkg: shared types, register codes and helpers for the Adam element update.
// No dependencies; imported by the moment, step and top-level modules.
package aoe_pkg;

  // One in Q1.31
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_LR  = 2'd0;
  localparam logic [1:0] REG_B1  = 2'd1;
  localparam logic [1:0] REG_B2  = 2'd2;
  localparam logic [1:0] REG_EPS = 2'd3;

  typedef struct packed {
    logic [31:0] lr;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] eps;
  } aoe_cfg_t;

  // A decay rate above one is taken as one
  function automatic logic [31:0] beta_sat(input logic [31:0] b);
    return (b > ONE_Q31) ? ONE_Q31 : b;
  endfunction

endpackage

[design/aoe_div.sv]
// aoe_div: pipelined restoring divider, one quotient bit per stage, with a side tag.
// Standalone; the initial remainder must be below the divisor for an exact quotient.
module aoe_div #(
  parameter int QW    = 32,
  parameter int DW    = 32,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_rem,
  input  logic [QW-1:0]    in_num,
  input  logic [DW-1:0]    in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [QW-1:0]    out_quo,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld [0:QW];
  logic [DW-1:0]    rem [0:QW];
  logic [QW-1:0]    num [0:QW];
  logic [QW-1:0]    quo [0:QW];
  logic [DW-1:0]    den [0:QW];
  logic [TAG_W-1:0] tag [0:QW];

  assign vld[0] = in_valid;
  assign rem[0] = in_rem;
  assign num[0] = in_num;
  assign quo[0] = '0;
  assign den[0] = in_den;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    // shift in the next dividend bit and try a subtract
    assign trial = {rem[k], num[k][QW-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? DW'(trial - {1'b0, den[k]}) : trial[DW-1:0];
        num[k+1] <= num[k] << 1;
        quo[k+1] <= {quo[k][QW-2:0], ge};
        den[k+1] <= den[k];
        tag[k+1] <= tag[k];
      end
    end
  end

  assign out_valid = vld[QW];
  assign out_quo   = quo[QW];
  assign out_tag   = tag[QW];

endmodule

[design/aoe_sqrt.sv]
// aoe_sqrt: pipelined integer square root, one root bit per stage, with a side tag.
// Standalone; XW must be even.
module aoe_sqrt #(
  parameter int XW    = 80,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [XW-1:0]    in_x,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [XW/2-1:0]  out_root,
  output logic [TAG_W-1:0] out_tag
);

  localparam int RW = XW / 2;

  logic             vld  [0:RW];
  logic [RW:0]      rem  [0:RW];
  logic [RW-1:0]    root [0:RW];
  logic [XW-1:0]    xs   [0:RW];
  logic [TAG_W-1:0] tag  [0:RW];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = in_x;
  assign tag[0]  = in_tag;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic [RW+2:0] rs;
    logic [RW+2:0] tr;
    logic          ge;

    // bring down the next bit pair, trial is 4*root+1
    assign rs = {rem[k], xs[k][XW-1:XW-2]};
    assign tr = {1'b0, root[k], 2'b01};
    assign ge = rs >= tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? (RW+1)'(rs - tr) : rs[RW:0];
        root[k+1] <= {root[k][RW-2:0], ge};
        xs[k+1]   <= xs[k] << 2;
        tag[k+1]  <= tag[k];
      end
    end
  end

  assign out_valid = vld[RW];
  assign out_root  = root[RW];
  assign out_tag   = tag[RW];

endmodule

[design/aoe_moments.sv]
// aoe_moments: three-stage update of the first and second moments.
// Depends on aoe_pkg for the configuration type and beta saturation.
module aoe_moments #(
  parameter int V = 32,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  aoe_pkg::aoe_cfg_t     cfg,
  input  logic                  in_valid,
  input  logic signed [V-1:0]   p,
  input  logic signed [V-1:0]   g,
  input  logic signed [V-1:0]   m,
  input  logic        [V-1:0]   v,
  input  logic        [31:0]    pw1,
  input  logic        [31:0]    pw2,
  output logic                  out_valid,
  output logic signed [V-1:0]   p_out,
  output logic signed [V-1:0]   m_new,
  output logic        [V-1:0]   v_new,
  output logic                  sat,
  output logic        [31:0]    bc1,
  output logic        [31:0]    bc2
);
  import aoe_pkg::*;

  localparam int TW  = ((V + F > 2 * V) ? V + 32 + F : 2 * V + 32) + 2;
  localparam int TSW = TW - 31 - F;

  logic [31:0] b1s, b2s, c1, c2;
  logic [V-1:0] gm;

  assign b1s = beta_sat(cfg.b1);
  assign b2s = beta_sat(cfg.b2);
  assign c1  = ONE_Q31 - b1s;
  assign c2  = ONE_Q31 - b2s;
  assign gm  = g[V-1] ? (~g + 1'b1) : g;

  // stage 1: products
  logic                 s1_valid;
  logic signed [V+32:0] s1_pm, s1_pg;
  logic [V+31:0]        s1_bv;
  logic [2*V-1:0]       s1_gsq;
  logic signed [V-1:0]  s1_p;
  logic [31:0]          s1_bc1, s1_bc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pm  <= m * $signed({1'b0, b1s});
      s1_pg  <= g * $signed({1'b0, c1});
      s1_bv  <= b2s * v;
      s1_gsq <= gm * gm;
      s1_p   <= p;
      s1_bc1 <= ONE_Q31 - pw1;
      s1_bc2 <= ONE_Q31 - pw2;
    end
  end

  // stage 2: first moment rounding, second moment partial products
  logic signed [V+33:0] acc, rnd;
  logic signed [V+2:0]  mn;
  logic                 m_hi, m_lo;

  assign acc  = s1_pm + s1_pg;
  assign rnd  = acc + (V+34)'(64'sd1 <<< 30);
  assign mn   = rnd[V+33:31];
  assign m_hi = !mn[V+2] && (|mn[V+1:V-1]);
  assign m_lo = mn[V+2] && !(&mn[V+1:V-1]);

  logic                s2_valid;
  logic signed [V-1:0] s2_p, s2_m;
  logic                s2_sat;
  logic [V+31:0]       s2_bv, s2_plo, s2_phi;
  logic [31:0]         s2_bc1, s2_bc2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_p   <= s1_p;
      if (m_hi) begin
        s2_m <= {1'b0, {(V-1){1'b1}}};
      end else if (m_lo) begin
        s2_m <= {1'b1, {(V-1){1'b0}}};
      end else begin
        s2_m <= mn[V-1:0];
      end
      s2_sat <= m_hi || m_lo;
      s2_bv  <= s1_bv;
      s2_plo <= c2 * s1_gsq[V-1:0];
      s2_phi <= c2 * s1_gsq[2*V-1:V];
      s2_bc1 <= s1_bc1;
      s2_bc2 <= s1_bc2;
    end
  end

  // stage 3: second moment sum, round and clip
  logic [TW-1:0]  tsum;
  logic [TSW-1:0] ts;
  logic           v_hi;

  assign tsum = (TW'(s2_bv) << F) + (TW'(s2_phi) << V) + TW'(s2_plo)
              + (TW'(1) << (30 + F));
  assign ts   = TSW'(tsum >> (31 + F));
  assign v_hi = |(ts >> V);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_out <= s2_p;
      m_new <= s2_m;
      v_new <= v_hi ? {V{1'b1}} : ts[V-1:0];
      sat   <= s2_sat || v_hi;
      bc1   <= s2_bc1;
      bc2   <= s2_bc2;
    end
  end

endmodule

[design/aoe_step.sv]
// aoe_step: step size lr*m_hat/(root+eps), parameter update and final clipping.
// Depends on aoe_pkg and aoe_div.
module aoe_step #(
  parameter int V  = 32,
  parameter int F  = 16,
  parameter int MW = 63,
  parameter int RW = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  aoe_pkg::aoe_cfg_t   cfg,
  input  logic                in_valid,
  input  logic signed [V-1:0] p,
  input  logic signed [V-1:0] m_new,
  input  logic        [V-1:0] v_new,
  input  logic                sat,
  input  logic                bcz,
  input  logic [MW-1:0]       mh,
  input  logic [RW-1:0]       root,
  output logic                out_valid,
  output logic signed [V-1:0] p_out,
  output logic signed [V-1:0] m_out,
  output logic        [V-1:0] v_out,
  output logic                sat_out
);
  import aoe_pkg::*;

  localparam int SW  = ((RW > 32) ? RW : 32) + 1;
  localparam int DW  = SW + 32 - F;
  localparam int H   = MW / 2;
  localparam int HW  = MW - H;
  localparam int NW  = 32 + MW;
  localparam int TPW = NW - V;
  localparam int CW  = (TPW > DW) ? TPW : DW;

  typedef struct packed {
    logic signed [V-1:0] p;
    logic signed [V-1:0] m;
    logic        [V-1:0] v;
    logic                sat;
    logic                bcz;
    logic                mhz;
  } stag_t;

  typedef struct packed {
    stag_t tg;
    logic  satq;
  } ftag_t;

  stag_t in_tg;
  assign in_tg = '{p: p, m: m_new, v: v_new, sat: sat, bcz: bcz, mhz: (mh == '0)};

  // E1: split product and denominator
  logic          e1_valid;
  stag_t         e1_tg;
  logic [31+H:0] e1_pl;
  logic [31+HW:0] e1_ph;
  logic [DW-1:0] e1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
    end else if (en) begin
      e1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_tg <= in_tg;
      e1_pl <= cfg.lr * mh[H-1:0];
      e1_ph <= cfg.lr * mh[MW-1:H];
      e1_d  <= DW'(SW'(root) + SW'(cfg.eps)) << (32 - F);
    end
  end

  // E2: join partial products
  logic          e2_valid;
  stag_t         e2_tg;
  logic [NW-1:0] e2_num;
  logic [DW-1:0] e2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      e2_valid <= 1'b0;
    end else if (en) begin
      e2_valid <= e1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e2_tg  <= e1_tg;
      e2_num <= NW'(e1_pl) + (NW'(e1_ph) << H);
      e2_d   <= e1_d;
    end
  end

  // E3: the quotient overflows the value range when num/2^V reaches d
  logic [TPW-1:0] top;
  logic           satq;

  assign top  = e2_num[NW-1:V];
  assign satq = !e2_tg.mhz && (CW'(top) >= CW'(e2_d));

  logic          e3_valid;
  ftag_t         e3_tg;
  logic [DW-1:0] e3_rem;
  logic [V-1:0]  e3_low;
  logic [DW-1:0] e3_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      e3_valid <= 1'b0;
    end else if (en) begin
      e3_valid <= e2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e3_tg  <= '{tg: e2_tg, satq: satq};
      e3_rem <= satq ? '0 : DW'(top);
      e3_low <= e2_num[V-1:0];
      e3_d   <= e2_d;
    end
  end

  // low V quotient bits
  logic         q_valid;
  logic [V-1:0] q;
  ftag_t        q_tg;

  aoe_div #(.QW(V), .DW(DW), .TAG_W($bits(ftag_t))) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (e3_valid),
    .in_rem   (e3_rem),
    .in_num   (e3_low),
    .in_den   (e3_d),
    .in_tag   (e3_tg),
    .out_valid(q_valid),
    .out_quo  (q),
    .out_tag  (q_tg)
  );

  // apply the step with the sign of the first moment
  logic [V-1:0]        stepm;
  logic signed [V+1:0] ps, pn;
  logic                p_hi, p_lo;

  assign stepm = q_tg.tg.mhz ? '0 : (q_tg.satq ? {V{1'b1}} : q);
  assign ps    = {{2{q_tg.tg.p[V-1]}}, q_tg.tg.p};
  assign pn    = q_tg.tg.m[V-1] ? ps + $signed({2'b00, stepm})
                                : ps - $signed({2'b00, stepm});
  assign p_hi  = !pn[V+1] && (|pn[V:V-1]);
  assign p_lo  = pn[V+1] && !(&pn[V:V-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_out <= q_tg.tg.m;
      v_out <= q_tg.tg.v;
      if (q_tg.tg.bcz) begin
        p_out   <= q_tg.tg.p;
        sat_out <= 1'b1;
      end else begin
        if (p_hi) begin
          p_out <= {1'b0, {(V-1){1'b1}}};
        end else if (p_lo) begin
          p_out <= {1'b1, {(V-1){1'b0}}};
        end else begin
          p_out <= pn[V-1:0];
        end
        sat_out <= q_tg.tg.sat || q_tg.satq || p_hi || p_lo;
      end
    end
  end

endmodule

[design/adam_optimizer_element_update.sv]
// adam_optimizer_element_update: streaming fixed-point Adam update, one element a beat.
// Depends on aoe_pkg, aoe_moments, aoe_div, aoe_sqrt and aoe_step.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------------
//  in      | in        | in_valid / in_stall      | step_start, param_value, grad_value,
//          |           |                          | moment_first_in, moment_second_in
//  out     | out       | out_valid / out_stall    | param_out, moment_first_out,
//          |           |                          | moment_second_out, saturated
//  cfg     | in        | psel/penable/pwrite, APB | step size, beta_first, beta_second,
//          |           |                          | epsilon_term at 0x0, 0x4, 0x8, 0xC
//
// One beat enters per cycle while in_stall is low. The whole pipeline moves on one enable;
// an output register plus a skid register let a beat be taken while a result waits, and
// in_stall rises only once the skid is full. Reset is synchronous: valid bits clear,
// beta powers return to one, registers to defaults.
module adam_optimizer_element_update #(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          step_start,
  input  logic signed [VALUE_WIDTH-1:0] param_value,
  input  logic signed [VALUE_WIDTH-1:0] grad_value,
  input  logic signed [VALUE_WIDTH-1:0] moment_first_in,
  input  logic        [VALUE_WIDTH-1:0] moment_second_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] param_out,
  output logic signed [VALUE_WIDTH-1:0] moment_first_out,
  output logic        [VALUE_WIDTH-1:0] moment_second_out,
  output logic                          saturated
);
  import aoe_pkg::*;

  localparam int V   = VALUE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int MW  = V + 31;
  localparam int XW0 = V + 31 + F;
  localparam int XW  = XW0 + (XW0 % 2);
  localparam int RW  = XW / 2;

  typedef struct packed {
    logic signed [V-1:0] p;
    logic signed [V-1:0] m;
    logic                sat;
  } dtag1_t;

  typedef struct packed {
    logic [V-1:0] v;
    logic         bcz;
  } dtag2_t;

  typedef struct packed {
    logic signed [V-1:0] p;
    logic signed [V-1:0] m;
    logic        [V-1:0] v;
    logic                sat;
    logic                bcz;
    logic [MW-1:0]       mh;
  } qtag_t;

  typedef struct packed {
    logic signed [V-1:0] p;
    logic signed [V-1:0] m;
    logic        [V-1:0] v;
    logic                sat;
  } res_t;

  // configuration registers
  aoe_cfg_t cfg;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lr  <= 32'd4294967;
      cfg.b1  <= 32'd1932735283;
      cfg.b2  <= 32'd2145336164;
      cfg.eps <= 32'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LR:  cfg.lr  <= pwdata;
        REG_B1:  cfg.b1  <= pwdata;
        REG_B2:  cfg.b2  <= pwdata;
        REG_EPS: cfg.eps <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LR:  prdata = cfg.lr;
      REG_B1:  prdata = cfg.b1;
      REG_B2:  prdata = cfg.b2;
      REG_EPS: prdata = cfg.eps;
      default: prdata = '0;
    endcase
  end

  // pipeline enable and input acceptance
  logic skid_full;
  logic en;
  logic in_acc;

  assign en       = !skid_full;
  assign in_stall = skid_full;
  assign in_acc   = in_valid && !in_stall;

  // running beta powers, bumped by the first beat of each step
  logic [31:0] pw1, pw2;
  logic [63:0] pp1, pp2;

  assign pp1 = pw1 * beta_sat(cfg.b1);
  assign pp2 = pw2 * beta_sat(cfg.b2);

  always_ff @(posedge clk) begin
    if (rst) begin
      pw1 <= ONE_Q31;
      pw2 <= ONE_Q31;
    end else if (in_acc && step_start) begin
      pw1 <= pp1[62:31];
      pw2 <= pp2[62:31];
    end
  end

  // input register
  logic                s0_valid;
  logic signed [V-1:0] s0_p, s0_g, s0_m;
  logic        [V-1:0] s0_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_p <= param_value;
      s0_g <= grad_value;
      s0_m <= moment_first_in;
      s0_v <= moment_second_in;
    end
  end

  // moment update
  logic                mo_valid;
  logic signed [V-1:0] mo_p, mo_m;
  logic        [V-1:0] mo_v;
  logic                mo_sat;
  logic [31:0]         mo_bc1, mo_bc2;

  aoe_moments #(.V(V), .F(F)) u_moments (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (s0_valid),
    .p        (s0_p),
    .g        (s0_g),
    .m        (s0_m),
    .v        (s0_v),
    .pw1      (pw1),
    .pw2      (pw2),
    .out_valid(mo_valid),
    .p_out    (mo_p),
    .m_new    (mo_m),
    .v_new    (mo_v),
    .sat      (mo_sat),
    .bc1      (mo_bc1),
    .bc2      (mo_bc2)
  );

  // bias correction: two dividers side by side
  logic [V-1:0] m_mag;
  dtag1_t       d1_in, d1_out;
  dtag2_t       d2_in, d2_out;
  logic         d1_valid, d2_valid;
  logic [MW-1:0] mh, vh;

  assign m_mag = mo_m[V-1] ? (~mo_m + 1'b1) : mo_m;
  assign d1_in = '{p: mo_p, m: mo_m, sat: mo_sat};
  assign d2_in = '{v: mo_v, bcz: (mo_bc1 == '0) || (mo_bc2 == '0)};

  aoe_div #(.QW(MW), .DW(32), .TAG_W($bits(dtag1_t))) u_div_m (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (mo_valid),
    .in_rem   (32'd0),
    .in_num   ({m_mag, 31'd0}),
    .in_den   (mo_bc1),
    .in_tag   (d1_in),
    .out_valid(d1_valid),
    .out_quo  (mh),
    .out_tag  (d1_out)
  );

  aoe_div #(.QW(MW), .DW(32), .TAG_W($bits(dtag2_t))) u_div_v (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (mo_valid),
    .in_rem   (32'd0),
    .in_num   ({mo_v, 31'd0}),
    .in_den   (mo_bc2),
    .in_tag   (d2_in),
    .out_valid(d2_valid),
    .out_quo  (vh),
    .out_tag  (d2_out)
  );

  // square root of v_hat in Q.F
  qtag_t         sq_in, sq_out;
  logic          sq_valid;
  logic [RW-1:0] root;

  assign sq_in = '{p: d1_out.p, m: d1_out.m, v: d2_out.v, sat: d1_out.sat,
                   bcz: d2_out.bcz, mh: mh};

  aoe_sqrt #(.XW(XW), .TAG_W($bits(qtag_t))) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (d1_valid),
    .in_x     (XW'({vh, {F{1'b0}}})),
    .in_tag   (sq_in),
    .out_valid(sq_valid),
    .out_root (root),
    .out_tag  (sq_out)
  );

  // step and parameter update
  logic fin_valid;
  res_t fin;

  aoe_step #(.V(V), .F(F), .MW(MW), .RW(RW)) u_step (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .cfg      (cfg),
    .in_valid (sq_valid),
    .p        (sq_out.p),
    .m_new    (sq_out.m),
    .v_new    (sq_out.v),
    .sat      (sq_out.sat),
    .bcz      (sq_out.bcz),
    .mh       (sq_out.mh),
    .root     (root),
    .out_valid(fin_valid),
    .p_out    (fin.p),
    .m_out    (fin.m),
    .v_out    (fin.v),
    .sat_out  (fin.sat)
  );

  // output register and skid
  res_t out_r, skid;
  logic load_out, load_skid;

  assign load_out  = skid_full ? !out_stall : (!out_valid || !out_stall);
  assign load_skid = !skid_full && out_valid && out_stall && fin_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!out_stall) begin
        skid_full <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= fin_valid;
    end else if (fin_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= skid_full ? skid : fin;
    end
    if (load_skid) begin
      skid <= fin;
    end
  end

  assign param_out         = out_r.p;
  assign moment_first_out  = out_r.m;
  assign moment_second_out = out_r.v;
  assign saturated         = out_r.sat;

`ifndef SYNTHESIS
  // a held skid beat always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid full without a valid output");

  // the two bias-correction dividers stay in lock step
  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    d1_valid == d2_valid)
    else $error("divider valid bits out of step");

  // beta powers never rise above one
  a_power_range: assert property (@(posedge clk) disable iff (rst)
    (pw1 <= ONE_Q31) && (pw2 <= ONE_Q31))
    else $error("beta power above one");

  // a stalled skid beat is kept until the output moves
  a_skid_hold: assert property (@(posedge clk) disable iff (rst)
    (skid_full && out_stall) |=> skid_full)
    else $error("skid beat lost under stall");
`endif

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for adam_optimizer_element_update.
// Depends on aoe_pkg and the design; predicts each result in SystemVerilog and checks it.
module testbench;
  import aoe_pkg::*;

  localparam int LATENCY = 160;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall;
  logic step_start = 1'b0;
  logic signed [31:0] param_value = '0, grad_value = '0, moment_first_in = '0;
  logic [31:0] moment_second_in = '0;
  logic out_valid, out_stall;
  logic signed [31:0] param_out, moment_first_out;
  logic [31:0] moment_second_out;
  logic saturated;

  typedef struct packed {
    logic [31:0] param;
    logic [31:0] m1;
    logic [31:0] m2;
    logic        sat;
  } update_t;

  update_t pending_updates[$];
  int errors = 0;
  bit hold_output = 1'b0;
  bit quiet_output = 1'b0;

  // predictor state
  logic [31:0] lr_reg, b1_reg, b2_reg, eps_reg;
  logic [31:0] step_cnt;
  logic [63:0] pow1, pow2;

  adam_optimizer_element_update u_dut (.*);

  always #5 clk = ~clk;

  // Integer square root of a 128-bit value
  function automatic logic [63:0] isqrt128(input logic [127:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if ({64'd0, trial} * {64'd0, trial} <= x) root = trial;
    end
    return root;
  endfunction

  // Work out one element's Adam update, advancing the step state on step_start
  function automatic update_t adam_update(input logic st, input logic signed [31:0] p,
                                          input logic signed [31:0] g,
                                          input logic signed [31:0] m,
                                          input logic [31:0] v);
    logic [63:0] b1, b2, bc1, bc2, gm, mh, vh, root, d, stepm;
    logic signed [127:0] acc, mnew, pnew;
    logic [127:0] t, q;
    update_t r;
    b1 = {32'd0, beta_sat(b1_reg)};
    b2 = {32'd0, beta_sat(b2_reg)};
    r.sat = 1'b0;
    if (st) begin
      step_cnt = step_cnt + 1;
      pow1 = (pow1 * b1) >> 31;
      pow2 = (pow2 * b2) >> 31;
    end
    acc = 128'sd0 + $signed(m) * $signed({1'b0, b1}) +
          $signed(g) * $signed({1'b0, 64'h8000_0000 - b1});
    mnew = (acc + (128'sd1 <<< 30)) >>> 31;
    if (mnew > 128'sd2147483647) begin mnew = 128'sd2147483647; r.sat = 1'b1; end
    if (mnew < -128'sd2147483648) begin mnew = -128'sd2147483648; r.sat = 1'b1; end
    gm = g < 0 ? 64'(-65'(g)) : 64'(g);
    t = (({64'd0, b2} * v) << 16) + {64'd0, 64'h8000_0000 - b2} * (gm * gm) + (128'd1 << 46);
    t = t >> 47;
    if (t > 128'hFFFF_FFFF) begin t = 128'hFFFF_FFFF; r.sat = 1'b1; end
    r.m1 = mnew[31:0];
    r.m2 = t[31:0];
    bc1 = 64'h8000_0000 - pow1;
    bc2 = 64'h8000_0000 - pow2;
    if (bc1 == 0 || bc2 == 0) begin
      r.sat = 1'b1;
      r.param = p;
    end else begin
      mh = ((mnew < 0 ? 64'(-mnew) : 64'(mnew)) << 31) / bc1;
      vh = ({32'd0, r.m2} << 31) / bc2;
      root = isqrt128({64'd0, vh} << 16);
      d = (root + eps_reg) << 16;
      if (mh == 0) stepm = 0;
      else if (d == 0) begin stepm = 64'hFFFF_FFFF; r.sat = 1'b1; end
      else begin
        q = ({96'd0, lr_reg} * {64'd0, mh}) / {64'd0, d};
        if (q > 128'hFFFF_FFFF) begin stepm = 64'hFFFF_FFFF; r.sat = 1'b1; end
        else stepm = q[63:0];
      end
      pnew = mnew < 0 ? 128'sd0 + p + $signed({64'd0, stepm})
                      : 128'sd0 + p - $signed({64'd0, stepm});
      if (pnew > 128'sd2147483647) begin pnew = 128'sd2147483647; r.sat = 1'b1; end
      if (pnew < -128'sd2147483648) begin pnew = -128'sd2147483648; r.sat = 1'b1; end
      r.param = pnew[31:0];
    end
    return r;
  endfunction

  // Register write over the configuration port, only while idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_LR:  lr_reg = val;
      REG_B1:  b1_reg = val;
      REG_B2:  b2_reg = val;
      default: eps_reg = val;
    endcase
  endtask

  // Send one beat, with an optional gap first; valid stays up after the beat is taken
  task automatic send_beat(input logic st, input logic [31:0] p, input logic [31:0] g,
                           input logic [31:0] m, input logic [31:0] v, input bit gaps);
    int gap;
    gap = 0;
    if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30)
                                                : $urandom_range(0, 2);
    if (gap != 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    step_start <= st; param_value <= p; grad_value <= g;
    moment_first_in <= m; moment_second_in <= v;
    pending_updates.push_back(adam_update(st, p, g, m, v));
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pending_updates.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(input int kind);
    case (kind)
      0: return $urandom();
      1: return $urandom_range(0, 65535) - 32768;
      2: return $urandom_range(0, 2000000) - 1000000;
      default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_beats(input int n);
    for (int i = 0; i < n; i++)
      send_beat($urandom_range(0, 15) == 0, rand_value($urandom_range(0, 3)),
                rand_value($urandom_range(0, 3)), rand_value($urandom_range(0, 3)),
                $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 300000), 1'b1);
  endtask

  // Receiver stall: random, or held high or held low on request
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_output) out_stall <= 1'b1;
    else if (quiet_output) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 9) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
  end
  initial out_stall = 1'b0;

  // Result checker
  always @(posedge clk) begin
    update_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_updates.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        want = pending_updates.pop_front();
        if (param_out !== want.param) begin
          $error("param_out exp %h got %h", want.param, param_out); errors++;
        end
        if (moment_first_out !== want.m1) begin
          $error("moment_first_out exp %h got %h", want.m1, moment_first_out); errors++;
        end
        if (moment_second_out !== want.m2) begin
          $error("moment_second_out exp %h got %h", want.m2, moment_second_out); errors++;
        end
        if (saturated !== want.sat) begin
          $error("saturated exp %b got %b", want.sat, saturated); errors++;
        end
      end
    end
  end

  // Elements before any step, then the field extremes
  task automatic test_directed;
    send_beat(1'b0, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0, 1'b0);
    send_beat(1'b1, 32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0, 1'b0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_beat(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_beat(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_beat(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 1'b0);
    send_beat(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_beat(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
    send_beat(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_beat(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    drain();
  endtask

  // Zero denominator, beta above one, of one and of zero, lr and eps extremes
  task automatic test_register_extremes;
    write_reg(REG_EPS, 32'h0);
    write_reg(REG_LR, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_beat(1'b0, 32'h10, 32'h0, 32'h1_0000, 32'h0, 1'b0);
    send_beat(1'b0, 32'h10, 32'h0, 32'h0, 32'h0, 1'b0);
    random_beats(30);
    drain();
    write_reg(REG_B1, 32'hFFFF_FFFF);
    write_reg(REG_B2, 32'h8000_0000);
    write_reg(REG_EPS, 32'hFFFF_FFFF);
    send_beat(1'b1, 32'h100, 32'h2_0000, 32'h1_0000, 32'h1_0000, 1'b0);
    random_beats(30);
    drain();
    write_reg(REG_B1, 32'h0);
    write_reg(REG_B2, 32'h0);
    write_reg(REG_LR, 32'h0);
    send_beat(1'b1, 32'h100, 32'h2_0000, 32'h1_0000, 32'h1_0000, 1'b0);
    random_beats(30);
    drain();
  endtask

  // Random settings with random beats, with one long receiver hold-off and one phase without stalls
  task automatic test_random_settings;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_LR, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 65535000));
      write_reg(REG_B1, $urandom_range(0, 32'h8000_0400));
      write_reg(REG_B2, $urandom_range(32'h7000_0000, 32'h8000_0000));
      write_reg(REG_EPS, $urandom_range(0, 1) ? $urandom_range(0, 100) : $urandom());
      if (ph == 3) begin
        fork
          begin
            hold_output = 1'b1;
            repeat (400) @(posedge clk);
            hold_output = 1'b0;
          end
          for (int i = 0; i < 200; i++)
            send_beat($urandom_range(0, 15) == 0, $urandom(), $urandom(), $urandom(),
                      $urandom(), 1'b0);
        join
      end else if (ph == 5) begin
        quiet_output = 1'b1;
        random_beats(150);
        quiet_output = 1'b0;
      end else begin
        random_beats(150);
      end
      // sender pauses until every result is back
      drain();
    end
  endtask

  initial begin
    lr_reg = 32'd4294967; b1_reg = 32'd1932735283; b2_reg = 32'd2145336164; eps_reg = 32'd1;
    step_cnt = '0; pow1 = 64'h8000_0000; pow2 = 64'h8000_0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_settings();
    if (errors == 0 && pending_updates.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule
